// File: hdl/gmps_pkg.sv
// Shared types and constants for the grid minimum path sum traceback unit.
package gmps_pkg;

   localparam int COST_W     = 16;
   localparam int SUM_W      = 21;
   localparam int CFG_W      = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int RSP_PAD_W  = 2;
   localparam int RSP_DATA_W = SUM_W + 1 + RSP_PAD_W;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b1;

   localparam logic DIR_DOWN  = 1'b0;
   localparam logic DIR_RIGHT = 1'b1;

   typedef logic signed [SUM_W-1:0] sum_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_TRACE_RD,
      ST_TRACE_USE,
      ST_TOTAL,
      ST_MOVES
   } state_type;

   // Turns a programmed grid size into the index of the last row or column.
   // Zero acts as one, anything above the maximum acts as the maximum.
   function automatic int last_index(input logic [CFG_W-1:0] v, input int maxv);
      int r;
      if (v == '0) begin
         r = 0;
      end else if (int'(v) > maxv) begin
         r = maxv - 1;
      end else begin
         r = int'(v) - 1;
      end
      return r;
   endfunction

endpackage

// File: hdl/gmps_sum_cell.sv
// One cell of the running row-sum shift chain.
module gmps_sum_cell (
   input  logic             clock,
   input  logic             shift_en,
   input  gmps_pkg::sum_type d_in,
   output gmps_pkg::sum_type d_out
);
   import gmps_pkg::*;

   sum_type sum_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         sum_ff <= d_in;
      end
   end

   assign d_out = sum_ff;

endmodule

// File: hdl/gmps_dir_mem.sv
// Direction bit memory, one write port and one registered read port.
module gmps_dir_mem #(
   parameter int AW = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data
);
   import gmps_pkg::*;

   logic mem_ff [2**AW];
   logic rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

// File: hdl/grid_min_path_sum_traceback_unit.sv
// Top level of the grid minimum path sum unit with path traceback.
//
//   Channel  Direction  Payload
//   req_     in         tdata[15:0] cell_cost
//   rsp_     out        tdata[20:0] total_cost, tdata[21] move_dir, tuser is_total,
//                       tlast last
//   csr_     in         index 0 rows_in_use, index 1 cols_in_use
//
// A cell is taken in every cycle while the grid fills; each one does a compare
// and a saturating add against the row-sum chain, whose tap sits at the last column index.
// After the last cell the traceback reads the direction memory in a read state and a use
// state per move and a final read state, then emits the total and the moves, one per cycle
// while rsp_tready is high.
// No cell is taken from the final cell until the last response transaction completes.
// Reset is synchronous and sets a one-by-one grid; the stores need no clearing.
module grid_min_path_sum_traceback_unit #(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gmps_pkg::COST_W-1:0]         req_tdata,   // cell_cost
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gmps_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // total_cost, move_dir
   output logic                                rsp_tuser,   // is_total
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [gmps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gmps_pkg::CFG_W-1:0]          csr_wdata
);
   import gmps_pkg::*;

   localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int AW  = RIW + CIW;
   localparam int STK = MAX_ROWS + MAX_COLS;
   localparam int NW  = $clog2(STK + 1);

   state_type state_ff, state_in;
   logic [RIW-1:0] rows_m1_ff, rows_m1_in;
   logic [CIW-1:0] cols_m1_ff, cols_m1_in;
   logic [RIW-1:0] row_ff, row_in;
   logic [CIW-1:0] col_ff, col_in;
   logic [RIW-1:0] tr_ff, tr_in;
   logic [CIW-1:0] tc_ff, tc_in;
   logic [STK-1:0] stack_ff, stack_in;
   logic [NW-1:0]  cnt_ff, cnt_in;
   sum_type        total_ff, total_in;

   logic           accept;
   sum_type        sum_q [MAX_COLS];
   sum_type        above, left_sum, base, new_sum;
   logic           dir_new, mem_rd, trace_dir;
   logic signed [SUM_W:0] wide;

   assign accept = req_tvalid && req_tready;

   // Row-sum chain: the newest sum is in cell 0, the one a row back sits at the tap.
   for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
      if (i == 0) begin : g_head
         gmps_sum_cell u_cell (
            .clock    (clock),
            .shift_en (accept),
            .d_in     (new_sum),
            .d_out    (sum_q[i])
         );
      end else begin : g_body
         gmps_sum_cell u_cell (
            .clock    (clock),
            .shift_en (accept),
            .d_in     (sum_q[i-1]),
            .d_out    (sum_q[i])
         );
      end
   end

   gmps_dir_mem #(.AW(AW)) u_dir_mem (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr ({row_ff, col_ff}),
      .wr_data (dir_new),
      .rd_addr ({tr_ff, tc_ff}),
      .rd_data (mem_rd)
   );

   assign above    = sum_q[cols_m1_ff];
   assign left_sum = sum_q[0];

   always_comb begin
      if (row_ff == '0 && col_ff == '0) begin
         base    = '0;
         dir_new = DIR_DOWN;
      end else if (row_ff == '0) begin
         base    = left_sum;
         dir_new = DIR_RIGHT;
      end else if (col_ff == '0) begin
         base    = above;
         dir_new = DIR_DOWN;
      end else if (above > left_sum) begin
         base    = left_sum;
         dir_new = DIR_RIGHT;
      end else begin
         base    = above;
         dir_new = DIR_DOWN;
      end
      wide = (SUM_W+1)'(base) + (SUM_W+1)'(signed'(req_tdata));
      if (wide[SUM_W] != wide[SUM_W-1]) begin
         new_sum = wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         new_sum = wide[SUM_W-1:0];
      end
   end

   // On the first row or column the move is forced, whatever the memory holds.
   assign trace_dir = (tr_ff == '0) ? DIR_RIGHT :
                      (tc_ff == '0) ? DIR_DOWN  : mem_rd;

   always_comb begin
      state_in   = state_ff;
      rows_m1_in = rows_m1_ff;
      cols_m1_in = cols_m1_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      tr_in      = tr_ff;
      tc_in      = tc_ff;
      stack_in   = stack_ff;
      cnt_in     = cnt_ff;
      total_in   = total_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_tdata  = '0;
      rsp_tuser  = 1'b0;
      rsp_tlast  = 1'b0;

      case (state_ff)
         ST_FILL: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (col_ff == cols_m1_ff) begin
                  col_in = '0;
                  if (row_ff == rows_m1_ff) begin
                     row_in   = '0;
                     total_in = new_sum;
                     tr_in    = rows_m1_ff;
                     tc_in    = cols_m1_ff;
                     cnt_in   = '0;
                     state_in = ST_TRACE_RD;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         ST_TRACE_RD: begin
            if (tr_ff == '0 && tc_ff == '0) begin
               state_in = ST_TOTAL;
            end else begin
               state_in = ST_TRACE_USE;
            end
         end
         ST_TRACE_USE: begin
            // Moves come out end first, so the stack hands them back start first.
            stack_in = {stack_ff[STK-2:0], trace_dir};
            cnt_in   = cnt_ff + 1'b1;
            if (trace_dir == DIR_RIGHT) begin
               tc_in = tc_ff - 1'b1;
            end else begin
               tr_in = tr_ff - 1'b1;
            end
            state_in = ST_TRACE_RD;
         end
         ST_TOTAL: begin
            rsp_tvalid = 1'b1;
            rsp_tuser  = 1'b1;
            rsp_tdata  = {{RSP_PAD_W{1'b0}}, DIR_DOWN, total_ff};
            rsp_tlast  = (cnt_ff == '0);
            if (rsp_tready) begin
               state_in = (cnt_ff == '0) ? ST_FILL : ST_MOVES;
            end
         end
         ST_MOVES: begin
            rsp_tvalid = 1'b1;
            rsp_tdata  = {{RSP_PAD_W{1'b0}}, stack_ff[0], {SUM_W{1'b0}}};
            rsp_tlast  = (cnt_ff == NW'(1));
            if (rsp_tready) begin
               stack_in = {1'b0, stack_ff[STK-1:1]};
               cnt_in   = cnt_ff - 1'b1;
               if (cnt_ff == NW'(1)) begin
                  state_in = ST_FILL;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase

      // A size write restarts the grid at its first cell.
      if (csr_we) begin
         case (csr_index)
            CSR_ROWS: begin
               rows_m1_in = RIW'(last_index(csr_wdata, MAX_ROWS));
               row_in     = '0;
               col_in     = '0;
            end
            CSR_COLS: begin
               cols_m1_in = CIW'(last_index(csr_wdata, MAX_COLS));
               row_in     = '0;
               col_in     = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_FILL;
         rows_m1_ff <= '0;
         cols_m1_ff <= '0;
         row_ff     <= '0;
         col_ff     <= '0;
         cnt_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         rows_m1_ff <= rows_m1_in;
         cols_m1_ff <= cols_m1_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      tr_ff    <= tr_in;
      tc_ff    <= tc_in;
      stack_ff <= stack_in;
      total_ff <= total_in;
   end

endmodule
